/* src/kvs_pkg.sv */
// Shared types, codes and constants of the keyed record store.
// Used by every module of the block but kvs_fifo; depends on nothing.
`timescale 1ns / 1ps

package kvs_pkg;

	localparam int STORE_BYTES_DEF     = 2048;
	localparam int MAX_VALUE_BYTES_DEF = 64;
	localparam int CMDQ_DEPTH          = 4;
	localparam int RESQ_DEPTH          = 4;

	// Record header layout, in bytes.
	localparam int HDR_BYTES = 12;
	localparam int KEY_BYTES = 8;
	localparam int CAP_OFS   = 8;
	localparam int LEN_OFS   = 10;

	// Input actions.
	localparam logic [2:0] A_GET   = 3'd0;
	localparam logic [2:0] A_PUT   = 3'd1;
	localparam logic [2:0] A_DEL   = 3'd2;
	localparam logic [2:0] A_CLR   = 3'd3;
	localparam logic [2:0] A_DATA  = 3'd4;

	// Command kinds after classification.
	localparam logic [2:0] K_GET  = 3'd0;
	localparam logic [2:0] K_PUT  = 3'd1;
	localparam logic [2:0] K_DEL  = 3'd2;
	localparam logic [2:0] K_CLR  = 3'd3;
	localparam logic [2:0] K_DATA = 3'd4;
	localparam logic [2:0] K_ERR  = 3'd5;

	// Status codes.
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_KEY_LONG     = 3'd1;
	localparam logic [2:0] ST_VALUE_BIG    = 3'd2;
	localparam logic [2:0] ST_CAP_MISMATCH = 3'd3;
	localparam logic [2:0] ST_FULL         = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND    = 3'd5;
	localparam logic [2:0] ST_DST_SMALL    = 3'd6;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] key;
		logic [6:0]  vlen;
		logic [6:0]  cap;
		logic [6:0]  dcap;
		logic [2:0]  status;
		logic [7:0]  data;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] found_length;
		logic [7:0] read_byte;
		logic       byte_valid;
		logic       last;
	} res_t;

	function automatic res_t mk_status(input logic [2:0] s);
		res_t r;
		r.status       = s;
		r.found_length = 7'd0;
		r.read_byte    = 8'd0;
		r.byte_valid   = 1'b0;
		r.last         = 1'b1;
		return r;
	endfunction

endpackage

/* src/kvs_fifo.sv */
// Small first-in first-out queue of flip-flops, used for commands and results.
// Depends on nothing.
`timescale 1ns / 1ps

module kvs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTRW-1:0]  wr_q, rd_q;
	logic [PTRW:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == (PTRW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTRW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTRW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* src/kvs_front.sv */
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on kvs_pkg and kvs_fifo.
`timescale 1ns / 1ps

module kvs_front #(
	parameter int MAX_VALUE_BYTES = kvs_pkg::MAX_VALUE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [2:0]    action,
	input  logic [63:0]   key_word,
	input  logic [3:0]    key_length,
	input  logic [6:0]    value_length,
	input  logic [6:0]    capacity,
	input  logic [6:0]    dest_capacity,
	input  logic [7:0]    data_byte,
	input  logic          init_busy,
	input  logic          cmd_pop,
	output kvs_pkg::cmd_t cmd,
	output logic          cmd_empty
);
	import kvs_pkg::*;

	localparam logic [6:0] MAXV = 7'(MAX_VALUE_BYTES);

	cmd_t                c;
	logic                q_full, q_push;
	logic [$bits(cmd_t)-1:0] q_rdata;

	always_comb begin
		c        = '0;
		c.vlen   = value_length;
		c.cap    = (capacity > MAXV) ? MAXV : capacity;
		c.dcap   = (dest_capacity > MAXV) ? MAXV : dest_capacity;
		c.data   = data_byte;
		c.status = ST_OK;
		for (int i = 0; i < KEY_BYTES; i++)
			c.key[8*i +: 8] = (4'(i) < key_length) ? key_word[8*i +: 8] : 8'd0;
		unique case (action)
			A_DATA: c.kind = K_DATA;
			A_CLR:  c.kind = K_CLR;
			A_GET, A_PUT, A_DEL: begin
				if (key_length > 4'(KEY_BYTES)) begin
					c.kind   = K_ERR;
					c.status = ST_KEY_LONG;
				end else if (action == A_PUT && value_length > c.cap) begin
					c.kind   = K_ERR;
					c.status = ST_VALUE_BIG;
				end else if (action == A_GET) begin
					c.kind = K_GET;
				end else if (action == A_PUT) begin
					c.kind = K_PUT;
				end else begin
					c.kind = K_DEL;
				end
			end
			default: c.kind = K_ERR;
		endcase
	end

	assign full   = q_full || init_busy;
	assign q_push = push && !full && (action <= A_DATA);
	assign cmd    = cmd_t'(q_rdata);

	kvs_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (c),
		.full   (q_full),
		.pop    (cmd_pop),
		.rdata  (q_rdata),
		.empty  (cmd_empty)
	);

endmodule

/* src/kvs_back.sv */
// Back end: byte store memory and the sequencer that walks and edits records.
// Depends on kvs_pkg.
`timescale 1ns / 1ps

module kvs_back #(
	parameter int STORE_BYTES = kvs_pkg::STORE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  kvs_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	output logic          res_push,
	output kvs_pkg::res_t res,
	input  logic          res_full,
	output logic          init_busy
);
	import kvs_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);
	localparam int PW = ((AW > 16) ? AW : 16) + 2;
	localparam logic [PW-1:0] STORE_W = PW'(STORE_BYTES);
	localparam logic [PW-1:0] HDR_W   = PW'(HDR_BYTES);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_HDR  = 4'd1;
	localparam logic [3:0] S_EVAL = 4'd2;
	localparam logic [3:0] S_WR   = 4'd3;
	localparam logic [3:0] S_GRD  = 4'd4;
	localparam logic [3:0] S_GWR  = 4'd5;
	localparam logic [3:0] S_DRD  = 4'd6;
	localparam logic [3:0] S_DWR  = 4'd7;
	localparam logic [3:0] S_ZERO = 4'd8;
	localparam logic [3:0] S_RES  = 4'd9;

	logic [7:0]    mem [STORE_BYTES];
	logic [7:0]    rdata_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0]    mem_wd;

	logic [3:0]    st_q, cnt_q;
	logic          quiet_q;
	logic [95:0]   hdr_q;
	logic [PW-1:0] p_q, q_q, gap_q;
	logic [6:0]    idx_q, glen_q, pend_q;
	logic [AW:0]   wa_q;
	cmd_t          cmd_q;
	res_t          res_q, gres;

	logic [63:0]   hkey;
	logic [15:0]   hcap, hlen;
	logic          is_end, is_found;
	logic [PW-1:0] hdr_addr, val_addr, src_addr, next_p, end_cap, end_len;
	logic [7:0]    wr_byte;
	logic          data_ok;

	assign hkey     = hdr_q[63:0];
	assign hcap     = hdr_q[79:64];
	assign hlen     = hdr_q[95:80];
	assign is_end   = (hkey == 64'd0);
	assign is_found = !is_end && (hkey == cmd_q.key);
	assign hdr_addr = p_q + PW'(cnt_q);
	assign val_addr = p_q + HDR_W + PW'(idx_q);
	assign src_addr = q_q + gap_q;
	assign next_p   = p_q + HDR_W + PW'(hcap);
	assign end_cap  = p_q + HDR_W + PW'(cmd_q.cap);
	assign end_len  = p_q + HDR_W + PW'(hlen);
	assign data_ok  = (pend_q != 7'd0) && (wa_q < (AW+1)'(STORE_BYTES));

	assign cmd_pop   = (st_q == S_IDLE) && !cmd_empty;
	assign init_busy = quiet_q;

	always_comb begin
		gres.status       = ST_OK;
		gres.found_length = glen_q;
		gres.read_byte    = rdata_q;
		gres.byte_valid   = 1'b1;
		gres.last         = (idx_q == glen_q - 7'd1);
	end
	assign res_push = (st_q == S_GWR) || ((st_q == S_RES) && !res_full);
	assign res      = (st_q == S_GWR) ? gres : res_q;

	always_comb begin
		case (cnt_q)
			4'(CAP_OFS):     wr_byte = {1'b0, cmd_q.cap};
			4'(LEN_OFS):     wr_byte = {1'b0, cmd_q.vlen};
			4'(CAP_OFS + 1): wr_byte = 8'd0;
			4'(LEN_OFS + 1): wr_byte = 8'd0;
			default:         wr_byte = 8'(cmd_q.key >> {cnt_q[2:0], 3'b000});
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = 8'd0;
		mem_re = 1'b0;
		mem_ra = '0;
		unique case (st_q)
			S_IDLE: begin
				if (!cmd_empty && cmd.kind == K_DATA && data_ok) begin
					mem_we = 1'b1;
					mem_wa = wa_q[AW-1:0];
					mem_wd = cmd.data;
				end
			end
			S_HDR: begin
				if (cnt_q < 4'(HDR_BYTES)) begin
					mem_re = 1'b1;
					mem_ra = hdr_addr[AW-1:0];
				end
			end
			S_WR: begin
				mem_we = 1'b1;
				mem_wa = hdr_addr[AW-1:0];
				mem_wd = wr_byte;
			end
			S_GRD: begin
				mem_re = !res_full;
				mem_ra = val_addr[AW-1:0];
			end
			S_DRD: begin
				mem_re = (src_addr < STORE_W);
				mem_ra = src_addr[AW-1:0];
			end
			S_DWR: begin
				mem_we = 1'b1;
				mem_wa = q_q[AW-1:0];
				mem_wd = rdata_q;
			end
			S_ZERO: begin
				mem_we = 1'b1;
				mem_wa = q_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_ZERO;
			quiet_q <= 1'b1;
			q_q     <= '0;
			wa_q    <= '0;
			pend_q  <= '0;
			cnt_q   <= '0;
			p_q     <= '0;
			idx_q   <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						cmd_q <= cmd;
						if (cmd.kind == K_DATA) begin
							if (data_ok) begin
								wa_q   <= wa_q + 1'b1;
								pend_q <= pend_q - 1'b1;
							end else begin
								pend_q <= '0;
							end
						end else begin
							pend_q <= '0;
							if (cmd.kind == K_ERR) begin
								res_q <= mk_status(cmd.status);
								st_q  <= S_RES;
							end else if (cmd.kind == K_CLR) begin
								q_q  <= '0;
								wa_q <= '0;
								st_q <= S_ZERO;
							end else begin
								p_q   <= '0;
								cnt_q <= '0;
								st_q  <= S_HDR;
							end
						end
					end
				end
				S_HDR: begin
					if (cnt_q != 4'd0)
						hdr_q <= {rdata_q, hdr_q[95:8]};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(HDR_BYTES))
						st_q <= S_EVAL;
				end
				S_EVAL: begin
					if (is_end || is_found) begin
						case (cmd_q.kind)
							K_GET: begin
								if (!is_found) begin
									res_q <= mk_status(ST_NOT_FOUND);
									st_q  <= S_RES;
								end else if (hlen > {9'd0, cmd_q.dcap}) begin
									res_q <= mk_status(ST_DST_SMALL);
									st_q  <= S_RES;
								end else if (end_len > STORE_W) begin
									res_q <= mk_status(ST_NOT_FOUND);
									st_q  <= S_RES;
								end else if (hlen == 16'd0) begin
									res_q <= mk_status(ST_OK);
									st_q  <= S_RES;
								end else begin
									glen_q <= hlen[6:0];
									idx_q  <= '0;
									st_q   <= S_GRD;
								end
							end
							K_PUT: begin
								if (is_end) begin
									if (end_cap > STORE_W) begin
										res_q <= mk_status(ST_FULL);
										st_q  <= S_RES;
									end else begin
										cnt_q <= '0;
										st_q  <= S_WR;
									end
								end else if ({9'd0, cmd_q.cap} > hcap) begin
									res_q <= mk_status(ST_CAP_MISMATCH);
									st_q  <= S_RES;
								end else begin
									cnt_q <= 4'(LEN_OFS);
									st_q  <= S_WR;
								end
							end
							default: begin
								if (is_found && next_p <= STORE_W) begin
									gap_q <= HDR_W + PW'(hcap);
									q_q   <= p_q;
									st_q  <= S_DRD;
								end else begin
									res_q <= mk_status(ST_NOT_FOUND);
									st_q  <= S_RES;
								end
							end
						endcase
					end else if (next_p >= STORE_W - HDR_W) begin
						res_q <= mk_status((cmd_q.kind == K_PUT) ? ST_FULL : ST_NOT_FOUND);
						st_q  <= S_RES;
					end else begin
						p_q   <= next_p;
						cnt_q <= '0;
						st_q  <= S_HDR;
					end
				end
				S_WR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(HDR_BYTES - 1)) begin
						wa_q   <= (AW+1)'(p_q + HDR_W);
						pend_q <= cmd_q.vlen;
						res_q  <= mk_status(ST_OK);
						st_q   <= S_RES;
					end
				end
				S_GRD: begin
					if (!res_full)
						st_q <= S_GWR;
				end
				S_GWR: begin
					idx_q <= idx_q + 1'b1;
					st_q  <= gres.last ? S_IDLE : S_GRD;
				end
				S_DRD: begin
					st_q <= (src_addr < STORE_W) ? S_DWR : S_ZERO;
				end
				S_DWR: begin
					q_q  <= q_q + 1'b1;
					st_q <= S_DRD;
				end
				S_ZERO: begin
					q_q <= q_q + 1'b1;
					if (q_q == STORE_W - 1'b1) begin
						if (quiet_q) begin
							quiet_q <= 1'b0;
							st_q    <= S_IDLE;
						end else begin
							res_q <= mk_status(ST_OK);
							st_q  <= S_RES;
						end
					end
				end
				S_RES: begin
					if (!res_full)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/keyed_record_store.sv */
// Top level of the keyed record store: front end, back end and result queue.
// Depends on kvs_pkg, kvs_fifo, kvs_front and kvs_back.
`timescale 1ns / 1ps

// Channel   | Handshake            | Transaction content
// ----------+----------------------+----------------------------------------------
// input     | push / full          | action, key_word, key_length, value_length,
//           |                      | capacity, dest_capacity, data_byte
// result    | pop / empty          | status, found_length, read_byte, byte_valid, last
//
// After reset the whole store is zeroed one byte a cycle, and full stays high until
// that sweep is over. A clear costs the same sweep. Every visited record header is
// read with twelve byte reads from the single registered read port, then evaluated;
// get, put and delete walk the records one header at a time. A get then reads and
// sends each value byte in turn, a put writes all twelve header bytes of a new record
// or only the two length bytes of an existing one, and a delete reads and writes each
// byte it moves down and then zero-fills the tail. A data byte is written directly
// from the idle state. Commands wait in a four-deep queue, so until it is full the
// input side keeps taking transactions while the back end is busy or stalled by pop.

module keyed_record_store #(
	parameter int STORE_BYTES     = kvs_pkg::STORE_BYTES_DEF,
	parameter int MAX_VALUE_BYTES = kvs_pkg::MAX_VALUE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  action,
	input  logic [63:0] key_word,
	input  logic [3:0]  key_length,
	input  logic [6:0]  value_length,
	input  logic [6:0]  capacity,
	input  logic [6:0]  dest_capacity,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [6:0]  found_length,
	output logic [7:0]  read_byte,
	output logic        byte_valid,
	output logic        last
);
	import kvs_pkg::*;

	cmd_t                    cmd;
	res_t                    bres, ores;
	logic                    cmd_empty, cmd_pop, res_push, res_full, init_busy;
	logic [$bits(res_t)-1:0] res_rdata;

	// The front classifies each transaction and drops unused actions.
	kvs_front #(
		.MAX_VALUE_BYTES (MAX_VALUE_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.key_word      (key_word),
		.key_length    (key_length),
		.value_length  (value_length),
		.capacity      (capacity),
		.dest_capacity (dest_capacity),
		.data_byte     (data_byte),
		.init_busy     (init_busy),
		.cmd_pop       (cmd_pop),
		.cmd           (cmd),
		.cmd_empty     (cmd_empty)
	);

	// The back end owns the store and carries out one command at a time.
	kvs_back #(
		.STORE_BYTES (STORE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (bres),
		.res_full  (res_full),
		.init_busy (init_busy)
	);

	// Results are held here so that a slow reader only stalls the back end.
	kvs_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RESQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (bres),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign ores         = res_t'(res_rdata);
	assign status       = ores.status;
	assign found_length = ores.found_length;
	assign read_byte    = ores.read_byte;
	assign byte_valid   = ores.byte_valid;
	assign last         = ores.last;

	// The back end must never offer a result the queue cannot take.
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	// Commands are only taken when one is waiting.
	a_no_cmd_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command taken from an empty queue");

	// No result can exist before the reset sweep ends.
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> (empty && cmd_empty))
		else $error("activity during the reset sweep");

endmodule
